>>> rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, constants and the microcode table of the Jacobi symbol unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int VALUE_WIDTH_DEF = 31;

  localparam int STEP_W = 2;

  localparam logic [2:0] MOD8_THREE = 3'd3;
  localparam logic [2:0] MOD8_FIVE  = 3'd5;
  localparam logic [1:0] MOD4_THREE = 2'd3;

  localparam logic signed [1:0] SYM_ZERO = 2'sb00;
  localparam logic signed [1:0] SYM_POS  = 2'sb01;
  localparam logic signed [1:0] SYM_NEG  = 2'sb11;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_FINISH,
    OP_HALVE,
    OP_SWAPSUB
  } op_t;

  typedef enum logic {
    COND_ALWAYS,
    COND_DISPATCH
  } cond_t;

  // Dispatch layout: target + 0 on zero or forced result, + 1 on even, + 2 on odd.
  localparam logic [STEP_W-1:0] STEP_LOAD    = 2'd0;
  localparam logic [STEP_W-1:0] STEP_FINISH  = 2'd1;
  localparam logic [STEP_W-1:0] STEP_HALVE   = 2'd2;
  localparam logic [STEP_W-1:0] STEP_SWAPSUB = 2'd3;

  localparam logic [STEP_W-1:0] DISP_EVEN = 2'd1;
  localparam logic [STEP_W-1:0] DISP_ODD  = 2'd2;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    op_t  op;
    logic fire;
  } seq_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic force_next;
    logic a_zero_next;
    logic a_odd_next;
  } dp_status_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      STEP_LOAD:    w = '{op: OP_LOAD,    cond: COND_DISPATCH, target: STEP_FINISH};
      STEP_FINISH:  w = '{op: OP_FINISH,  cond: COND_ALWAYS,   target: STEP_LOAD};
      STEP_HALVE:   w = '{op: OP_HALVE,   cond: COND_DISPATCH, target: STEP_FINISH};
      STEP_SWAPSUB: w = '{op: OP_SWAPSUB, cond: COND_DISPATCH, target: STEP_FINISH};
      default:      w = '{op: OP_LOAD,    cond: COND_DISPATCH, target: STEP_FINISH};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/jsu_req_if.sv
// ----------------------------------------------------------------------------
// jsu_req_if
// Request channel: one odd modulus per request.
// ----------------------------------------------------------------------------
interface jsu_req_if
  import jsu_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface

>>> rtl/core/jsu_rsp_if.sv
// ----------------------------------------------------------------------------
// jsu_rsp_if
// Response channel: symbol and bad-modulus flag.
// ----------------------------------------------------------------------------
interface jsu_rsp_if ();
  logic              valid;
  logic              ready;
  logic signed [1:0] symbol;
  logic              bad_modulus;

  modport source (output valid, output symbol, output bad_modulus, input ready);
  modport sink   (input valid, input symbol, input bad_modulus, output ready);
endinterface

>>> rtl/core/jsu_sequencer.sv
// ----------------------------------------------------------------------------
// jsu_sequencer
// Step counter over the microcode table with stall and three-way dispatch.
// ----------------------------------------------------------------------------
module jsu_sequencer
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t status,
  output seq_ctrl_t  ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            word;
  logic              stall;

  always_comb begin
    word  = ucode_rom(step);
    stall = ((word.op == OP_LOAD) && !status.in_valid) ||
            ((word.op == OP_FINISH) && !status.out_free);
    ctrl.op   = word.op;
    ctrl.fire = !stall;
  end

  always_comb begin
    step_next = step;
    if (!stall) begin
      case (word.cond)
        COND_ALWAYS: step_next = word.target;
        COND_DISPATCH: begin
          if (status.force_next || status.a_zero_next) begin
            step_next = word.target;
          end else if (!status.a_odd_next) begin
            step_next = word.target + DISP_EVEN;
          end else begin
            step_next = word.target + DISP_ODD;
          end
        end
        default: step_next = STEP_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> rtl/core/jsu_datapath.sv
// ----------------------------------------------------------------------------
// jsu_datapath
// Operand registers, sign, halve and swap-subtract units, result register.
// ----------------------------------------------------------------------------
module jsu_datapath
  import jsu_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  seq_ctrl_t              ctrl,
  input  logic [VALUE_WIDTH-1:0] numerator,
  input  logic                   in_valid,
  input  logic [VALUE_WIDTH-1:0] modulus,
  input  logic                   out_ready,
  output logic                   in_ready,
  output logic                   out_valid,
  output logic signed [1:0]      symbol,
  output logic                   bad_modulus,
  output dp_status_t             status
);

  logic [VALUE_WIDTH-1:0] a;
  logic [VALUE_WIDTH-1:0] a_next;
  logic [VALUE_WIDTH-1:0] n;
  logic [VALUE_WIDTH-1:0] n_next;
  logic                   neg;
  logic                   neg_next;
  logic                   force_zero;
  logic                   force_zero_next;
  logic                   bad;
  logic                   bad_next;
  logic [VALUE_WIDTH:0]   diff;
  logic                   a_lt_n;
  logic                   flip8;
  logic                   flip4;
  logic                   in_bad;
  logic signed [1:0]      result;

  always_comb begin
    diff   = {1'b0, a} - {1'b0, n};
    a_lt_n = diff[VALUE_WIDTH];
    flip8  = (n[2:0] == MOD8_THREE) || (n[2:0] == MOD8_FIVE);
    flip4  = (a[1:0] == MOD4_THREE) && (n[1:0] == MOD4_THREE);
    in_bad = (modulus == '0) || !modulus[0];
  end

  always_comb begin
    a_next          = a;
    n_next          = n;
    neg_next        = neg;
    force_zero_next = force_zero;
    bad_next        = bad;
    case (ctrl.op)
      OP_LOAD: begin
        a_next          = numerator;
        n_next          = modulus;
        neg_next        = 1'b0;
        bad_next        = in_bad;
        force_zero_next = in_bad || (modulus == VALUE_WIDTH'(1));
      end
      OP_HALVE: begin
        a_next   = a >> 1;
        neg_next = neg ^ flip8;
      end
      OP_SWAPSUB: begin
        if (a_lt_n) begin
          a_next   = n - a;
          n_next   = a;
          neg_next = neg ^ flip4;
        end else begin
          a_next = diff[VALUE_WIDTH-1:0];
        end
      end
      OP_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (force_zero || (n != VALUE_WIDTH'(1))) begin
      result = SYM_ZERO;
    end else if (neg) begin
      result = SYM_NEG;
    end else begin
      result = SYM_POS;
    end
  end

  always_comb begin
    in_ready           = (ctrl.op == OP_LOAD) && !rst;
    status.in_valid    = in_valid;
    status.out_free    = !out_valid || out_ready;
    status.force_next  = force_zero_next;
    status.a_zero_next = (a_next == '0);
    status.a_odd_next  = a_next[0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      a          <= a_next;
      n          <= n_next;
      neg        <= neg_next;
      force_zero <= force_zero_next;
      bad        <= bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fire && (ctrl.op == OP_FINISH)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire && (ctrl.op == OP_FINISH)) begin
      symbol      <= result;
      bad_modulus <= bad;
    end
  end

endmodule

>>> rtl/core/jacobi_symbol_unit.sv
// ----------------------------------------------------------------------------
// jacobi_symbol_unit
// Jacobi symbol of a configured numerator over each requested odd modulus,
// run by a four-word microcode program over a binary reduction datapath.
//
//   channel   dir  payload                      handshake
//   req       in   modulus [VALUE_WIDTH-1:0]    valid / ready
//   rsp       out  symbol [1:0], bad_modulus    valid / ready
//   cfg       in   cfg_wdata [VALUE_WIDTH-1:0]  cfg_we, no wait
//
// A request runs a load step, its halving and swap-subtract steps, and a finish
// step. Halvings stay under 2 * VALUE_WIDTH and swap-subtract steps exceed
// them by at most one. The sequencer loop runs one datapath step per cycle,
// but holds on the load step until req.valid and on the finish step until
// the output register is free.
// Reset clears the step counter, the result valid and the numerator to zero.
// A new request is taken while a result still waits in the output register;
// a stalled result holds until rsp.ready.
// ----------------------------------------------------------------------------
module jacobi_symbol_unit
  import jsu_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [VALUE_WIDTH-1:0] cfg_wdata,
  jsu_req_if.sink                req,
  jsu_rsp_if.source              rsp
);

  logic [VALUE_WIDTH-1:0] numerator_value;
  seq_ctrl_t              ctrl;
  dp_status_t             status;

  always_ff @(posedge clk) begin
    if (rst) begin
      numerator_value <= '0;
    end else if (cfg_we) begin
      numerator_value <= cfg_wdata;
    end
  end

  jsu_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  jsu_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .numerator   (numerator_value),
    .in_valid    (req.valid),
    .modulus     (req.modulus),
    .out_ready   (rsp.ready),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .symbol      (rsp.symbol),
    .bad_modulus (rsp.bad_modulus),
    .status      (status)
  );

  a_no_back_to_back_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken twice without a finish step");

  a_finish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (ctrl.fire && (ctrl.op == OP_FINISH)) |=> rsp.valid)
    else $error("finish step did not post a result");

  a_symbol_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.symbol != 2'sb10))
    else $error("symbol code out of range");

  a_bad_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.bad_modulus) |-> (rsp.symbol == SYM_ZERO))
    else $error("bad modulus with nonzero symbol");

endmodule

>>> tb/jacobi_symbol_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jacobi_symbol_unit_tb
// Sends odd, even and zero moduli against a series of numerator settings.
// Each response is checked field by field against the typed entry of its
// directed row or a bit-accurate Jacobi symbol predictor. Both channels idle
// at random, and one long response hold-off backs the unit up into its request port.
// ----------------------------------------------------------------------------
module jacobi_symbol_unit_tb;
  import jsu_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  localparam logic [VW-1:0] MOD_MAX  = {VW{1'b1}};
  localparam logic [VW-1:0] MOD_EVEN = {{(VW-1){1'b1}}, 1'b0};
  localparam int ITEMS_PER_PHASE = 170;
  localparam int NUM_PHASES = 6;
  localparam int DRAIN_CYCLES = 2 * VW + 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DIR_N = 25;

  typedef struct packed {
    logic signed [1:0] symbol;
    logic              bad_modulus;
  } sym_result_t;

  typedef struct packed {
    logic [VW-1:0]     numer;
    logic [VW-1:0]     modulus;
    logic              typed;
    logic signed [1:0] symbol;
    logic              bad_modulus;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{31'd0, 31'd0, 1'b1, SYM_ZERO, 1'b1},
    '{31'd0, 31'd2, 1'b1, SYM_ZERO, 1'b1},
    '{31'd0, 31'd1, 1'b1, SYM_ZERO, 1'b0},
    '{31'd0, 31'd3, 1'b1, SYM_ZERO, 1'b0},
    '{31'd0, MOD_MAX, 1'b1, SYM_ZERO, 1'b0},
    '{31'd0, MOD_EVEN, 1'b1, SYM_ZERO, 1'b1},
    '{31'd1, 31'd1, 1'b1, SYM_ZERO, 1'b0},
    '{31'd1, 31'd3, 1'b1, SYM_POS, 1'b0},
    '{31'd1, MOD_MAX, 1'b1, SYM_POS, 1'b0},
    '{31'd2, 31'd3, 1'b0, SYM_ZERO, 1'b0},
    '{31'd2, 31'd5, 1'b0, SYM_ZERO, 1'b0},
    '{31'd2, 31'd7, 1'b0, SYM_ZERO, 1'b0},
    '{31'd2, 31'd0, 1'b1, SYM_ZERO, 1'b1},
    '{MOD_MAX, MOD_MAX, 1'b1, SYM_ZERO, 1'b0},
    '{MOD_MAX, 31'd1, 1'b1, SYM_ZERO, 1'b0},
    '{MOD_MAX, 31'd3, 1'b0, SYM_ZERO, 1'b0},
    '{MOD_MAX, 31'h7FFF_FFFD, 1'b0, SYM_ZERO, 1'b0},
    '{31'd15, 31'd9, 1'b1, SYM_ZERO, 1'b0},
    '{31'd15, 31'd21, 1'b1, SYM_ZERO, 1'b0},
    '{31'd15, 31'd7, 1'b0, SYM_ZERO, 1'b0},
    '{31'd15, 31'd17, 1'b0, SYM_ZERO, 1'b0},
    '{31'd5, 31'h2AAA_AAAB, 1'b0, SYM_ZERO, 1'b0},
    '{31'h5555_5555, 31'h2AAA_AAAB, 1'b0, SYM_ZERO, 1'b0},
    '{31'h2AAA_AAAA, 31'h5555_5555, 1'b0, SYM_ZERO, 1'b0},
    '{MOD_MAX, 31'h4000_0001, 1'b0, SYM_ZERO, 1'b0}
  };

  logic          clk;
  logic          rst;
  logic          cfg_we;
  logic [VW-1:0] cfg_wdata;

  jsu_req_if #(.VALUE_WIDTH(VW)) req_ch ();
  jsu_rsp_if                     rsp_ch ();

  jacobi_symbol_unit #(
    .VALUE_WIDTH(VW)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  sym_result_t   expected_symbols [$];
  logic [VW-1:0] numer_shadow;
  int            errors;
  int            checked;
  int            neg_seen;
  int            pos_seen;
  int            zero_seen;
  int            bad_seen;
  int            cfg_writes;
  int            stall_left;
  bit            no_idle;
  bit            pressure_go;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #10_000_000;
    $display("** jacobi_symbol_unit: FAILED **");
    $finish;
  end

  function automatic sym_result_t predict_symbol(input logic [VW-1:0] numer,
                                                 input logic [VW-1:0] modulus);
    sym_result_t       r;
    logic [VW-1:0]     a;
    logic [VW-1:0]     n;
    logic [VW-1:0]     t;
    logic signed [1:0] sign;
    r.symbol = SYM_ZERO;
    r.bad_modulus = 1'b0;
    if (modulus == '0 || !modulus[0]) begin
      r.bad_modulus = 1'b1;
      return r;
    end
    a = numer % modulus;
    n = modulus;
    sign = SYM_POS;
    if (a == '0) return r;
    while (a != '0) begin
      while (!a[0]) begin
        a = a >> 1;
        if (n[2:0] == MOD8_THREE || n[2:0] == MOD8_FIVE)
          sign = (sign == SYM_POS) ? SYM_NEG : SYM_POS;
      end
      t = a;
      a = n;
      n = t;
      if (a[1:0] == MOD4_THREE && n[1:0] == MOD4_THREE)
        sign = (sign == SYM_POS) ? SYM_NEG : SYM_POS;
      a = a % n;
    end
    r.symbol = (n == VW'(1)) ? sign : SYM_ZERO;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VW-1:0] next_modulus();
    int            r;
    logic [VW-1:0] m;
    r = $urandom_range(0, 99);
    m = VW'($urandom);
    if (r < 68) m[0] = 1'b1;
    else if (r < 80) m = VW'($urandom_range(0, 63) * 2 + 1);
    else if (r < 87) m[0] = 1'b0;
    else if (r < 89) m = '0;
    else if (r < 93) m = MOD_MAX;
    else if (r < 95) m = VW'(1);
    else if (numer_shadow[0]) m = numer_shadow;
    else m[0] = 1'b1;
    return m;
  endfunction

  task automatic write_numerator(input logic [VW-1:0] value);
    wait (expected_symbols.size() == 0);
    repeat (2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    numer_shadow = value;
    cfg_writes++;
  endtask

  task automatic send_request(input logic [VW-1:0] modulus, input int gap,
                              input bit typed, input sym_result_t typed_exp);
    sym_result_t exp_r;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.modulus <= modulus;
    do @(posedge clk); while (!req_ch.ready);
    exp_r = typed ? typed_exp : predict_symbol(numer_shadow, modulus);
    expected_symbols = {expected_symbols, exp_r};
  endtask

  initial begin
    wait (rst === 1'b1);
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (pressure_go) begin
        pressure_go = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_response
    sym_result_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_symbols.size() == 0) begin
        $display("%0t: unexpected response symbol=%0d bad_modulus=%0b", $time,
                 rsp_ch.symbol, rsp_ch.bad_modulus);
        errors++;
      end else begin
        exp_r = expected_symbols.pop_front();
        checked++;
        if (rsp_ch.symbol !== exp_r.symbol) begin
          $display("%0t: symbol mismatch expected=%0d actual=%0d", $time,
                   exp_r.symbol, rsp_ch.symbol);
          errors++;
        end
        if (rsp_ch.bad_modulus !== exp_r.bad_modulus) begin
          $display("%0t: bad_modulus mismatch expected=%0b actual=%0b", $time,
                   exp_r.bad_modulus, rsp_ch.bad_modulus);
          errors++;
        end
        if (rsp_ch.bad_modulus) bad_seen++;
        else if (rsp_ch.symbol == SYM_NEG) neg_seen++;
        else if (rsp_ch.symbol == SYM_POS) pos_seen++;
        else zero_seen++;
      end
    end
  end

  initial begin : stimulus
    sym_result_t   typed_exp;
    logic [VW-1:0] phase_numer;
    int            root;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.modulus = '0;
    rsp_ch.ready = 1'b0;
    numer_shadow = '0;
    errors = 0;
    checked = 0;
    neg_seen = 0;
    pos_seen = 0;
    zero_seen = 0;
    bad_seen = 0;
    cfg_writes = 0;
    stall_left = 0;
    no_idle = 1'b0;
    pressure_go = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].numer != numer_shadow) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        write_numerator(DIR_ROWS[i].numer);
      end
      typed_exp.symbol = DIR_ROWS[i].symbol;
      typed_exp.bad_modulus = DIR_ROWS[i].bad_modulus;
      send_request(DIR_ROWS[i].modulus, pick_gap(), DIR_ROWS[i].typed, typed_exp);
    end

    typed_exp = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_numer = VW'($urandom);
        1: phase_numer = MOD_MAX;
        2: phase_numer = '0;
        3: phase_numer = VW'($urandom_range(1, 255));
        4: begin
          root = $urandom_range(1, 46340);
          phase_numer = VW'(root * root);
        end
        default: phase_numer = ~numer_shadow;
      endcase
      @(negedge clk);
      req_ch.valid <= 1'b0;
      write_numerator(phase_numer);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        no_idle = (i >= 60 && i < 100);
        send_request(next_modulus(), pick_gap(), 1'b0, typed_exp);
        if (p == 1 && i == 20) pressure_go = 1'b1;
      end
      no_idle = 1'b0;
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;

    wait (expected_symbols.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d responses over %0d numerator writes", checked, cfg_writes);
    $display("symbols: -1 x%0d, 0 x%0d, +1 x%0d, bad modulus x%0d",
             neg_seen, zero_seen, pos_seen, bad_seen);
    if (errors == 0) begin
      $display("** jacobi_symbol_unit: PASSED **");
    end else begin
      $display("** jacobi_symbol_unit: FAILED **");
    end
    $finish;
  end

endmodule
